[hdl/rdsm_pkg.sv]
package rdsm_pkg;

  // Operation carried in the input tuser
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_END    = 2'd3
  } func_e;

  localparam logic [7:0] WILDCARD_SYM = 8'd46;

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 8;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic             step;   // advance the active set by one text symbol
    logic             rearm;  // restart at position zero
    logic [SYM_W-1:0] text;   // current text symbol
  } cell_ctl_t;

  // Token load into one cell
  typedef struct packed {
    logic             wr;
    logic [SYM_W-1:0] sym;
    logic             star;
  } tok_load_t;

endpackage

[hdl/rdsm_cell.sv]
module rdsm_cell
  import rdsm_pkg::*;
#(
  parameter logic HEAD = 1'b0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  tok_load_t load_i,
  input  logic      en_i,      // token lies inside the loaded pattern
  input  logic      clos_i,    // skip over the previous starred token
  input  logic      fwd_i,     // previous token consumed a symbol
  output logic      clos_o,
  output logic      fwd_o,
  output logic      closed_o   // this position active after closure
);

  logic [SYM_W-1:0] sym_q;
  logic             star_q;
  logic             act_q, act_d;
  logic             hit;

  // Hold the token of this position
  always_ff @(posedge clk_i) begin
    if (load_i.wr) begin
      sym_q  <= load_i.sym;
      star_q <= load_i.star;
    end
  end

  // Closure and symbol match
  always_comb begin
    closed_o = act_q | clos_i;
    clos_o   = closed_o & star_q & en_i;
    hit      = closed_o & en_i & ((sym_q == WILDCARD_SYM) || (sym_q == ctl_i.text));
    fwd_o    = hit & ~star_q;
  end

  // Advance the active bit
  always_comb begin
    priority if (ctl_i.rearm) begin
      act_d = HEAD;
    end else if (ctl_i.step) begin
      act_d = (hit & star_q) | fwd_i;
    end else begin
      act_d = act_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= HEAD;
    end else begin
      act_q <= act_d;
    end
  end

endmodule

[hdl/regex_dot_star_matcher.sv]
// Channel  Dir  tdata                                tuser
// s_axis   in   [7:0] symbol, [8] starred, pad      [1:0] func
// m_axis   out  [0] matched, [1] overflow, pad      -
//
// One item per cycle: every cell updates its position in parallel, the
// closure over starred tokens ripples through the cell row in the same cycle.
// Only an end-of-text item gives a result; an output register plus a skid
// stage hold up to two results, s_axis_tready drops only when both are full.
// Reset leaves an empty pattern with only position zero active.
module regex_dot_star_matcher
  import rdsm_pkg::*;
#(
  parameter int unsigned MAX_TOKENS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] symbol, [8] starred
  input  logic [1:0]            s_axis_tuser,  // [1:0] func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // [0] matched, [1] overflow
);

  localparam int unsigned LW = $clog2(MAX_TOKENS + 1);

  func_e            func;
  logic             accept;
  cell_ctl_t        ctl;
  logic [LW-1:0]    len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             full;
  logic [MAX_TOKENS:0] clos, fwd, closed_pos;
  logic             act_top_q, act_top_d;
  logic             res_match;
  logic             push, pop;
  logic             out_valid_q, skid_valid_q;
  logic [1:0]       out_q, skid_q;

  assign func   = func_e'(s_axis_tuser);
  assign accept = s_axis_tvalid & s_axis_tready;
  assign full   = (len_q == LW'(MAX_TOKENS));

  assign ctl.step  = accept && (func == FUNC_TEXT);
  assign ctl.rearm = accept && (func != FUNC_TEXT);
  assign ctl.text  = s_axis_tdata[SYM_W-1:0];

  assign clos[0] = 1'b0;
  assign fwd[0]  = 1'b0;

  // Row of position cells
  for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
    tok_load_t load;
    logic      en;

    assign load.wr   = accept && (func == FUNC_APPEND) && (len_q == LW'(i));
    assign load.sym  = s_axis_tdata[SYM_W-1:0];
    assign load.star = s_axis_tdata[SYM_W];
    assign en        = (LW'(i) < len_q);

    rdsm_cell #(
      .HEAD ((i == 0) ? 1'b1 : 1'b0)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .load_i   (load),
      .en_i     (en),
      .clos_i   (clos[i]),
      .fwd_i    (fwd[i]),
      .clos_o   (clos[i+1]),
      .fwd_o    (fwd[i+1]),
      .closed_o (closed_pos[i])
    );
  end

  // Position past the last token
  assign closed_pos[MAX_TOKENS] = act_top_q | clos[MAX_TOKENS];
  assign res_match              = closed_pos[len_q];

  always_comb begin
    priority if (ctl.rearm) begin
      act_top_d = 1'b0;
    end else if (ctl.step) begin
      act_top_d = fwd[MAX_TOKENS];
    end else begin
      act_top_d = act_top_q;
    end
  end

  // Pattern length and sticky overflow
  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (accept) begin
      unique case (func)
        FUNC_CLEAR: begin
          len_d = '0;
          ovf_d = 1'b0;
        end
        FUNC_APPEND: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + LW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      ovf_q     <= 1'b0;
      act_top_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      act_top_q <= act_top_d;
    end
  end

  // Result output register with skid stage
  assign push          = accept && (func == FUNC_END);
  assign pop           = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = ~skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= {ovf_q, res_match};
      end else begin
        skid_q <= {ovf_q, res_match};
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item while the output register is empty");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_TOKENS))
    else $error("pattern length beyond capacity");

  a_clear_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func == FUNC_CLEAR)) |=> (len_q == '0) && !ovf_q)
    else $error("clear did not empty the pattern");

  a_rearm_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.rearm |=> closed_pos[0] && !act_top_q)
    else $error("rearm did not restart at position zero");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func == FUNC_APPEND) && full) |=> ovf_q && $stable(len_q))
    else $error("append to a full pattern changed the length or missed overflow");
`endif

endmodule
